// ----- rtl/sspt_pkg.sv -----
// ----------------------------------------------------------------------------
// sspt_pkg
// Shared types and constants of the SSTV pixel sample-time pipeline.
// ----------------------------------------------------------------------------
package sspt_pkg;

   // field widths
   localparam int Y_W      = 9;     // line index
   localparam int X_W      = 10;    // column index
   localparam int CH_W     = 2;     // colour channel
   localparam int TIME_W   = 40;    // sample time
   localparam int PIX_W    = 11;    // pixels per line
   localparam int PERIOD_W = 31;    // line period
   localparam int DUR_W    = 30;    // sync / porch / scan / separator
   localparam int LAYOUT_W = 3;
   localparam int CSR_A_W  = 3;
   localparam int CSR_D_W  = 31;

   // datapath widths
   localparam int MLT_W    = Y_W + 1;          // line factor y, y/2 or y+1
   localparam int KF_W     = PIX_W + 2;        // numerator factor, at most 6141
   localparam int LPROD_W  = MLT_W + PERIOD_W; // line factor * period
   localparam int NUM_W    = KF_W + DUR_W;     // divider numerator
   localparam int OPR_W    = DUR_W + 1;        // one addend, up to twice a duration
   localparam int ADD_W    = OPR_W + 3;        // sum of four addends
   localparam int BASE_W   = LPROD_W + 1;      // line product + addend sum
   localparam int DVS_W    = PIX_W + 2;        // divisor 4n
   localparam int SUM_W    = NUM_W + 1;        // base + quotient

   localparam logic [Y_W:0]    MAX_LINES  = (Y_W + 1)'(512);
   localparam logic [X_W:0]    MAX_PIXELS = (X_W + 1)'(1024);
   localparam logic [SUM_W-1:0] TIME_MAX  = SUM_W'((64'd1 << TIME_W) - 64'd1);

   // channel numbers; channel three is never transmitted
   localparam logic [CH_W-1:0] CHAN_0 = 2'd0;
   localparam logic [CH_W-1:0] CHAN_1 = 2'd1;
   localparam logic [CH_W-1:0] CHAN_2 = 2'd2;
   localparam logic [CH_W-1:0] CHAN_3 = 2'd3;

   // timing layouts
   typedef enum logic [LAYOUT_W-1:0] {
      LAYOUT_SEQ     = 3'd0,
      LAYOUT_SCOTTIE = 3'd1,
      LAYOUT_PD      = 3'd2,
      LAYOUT_R72     = 3'd3,
      LAYOUT_R36     = 3'd4
   } layout_type;

   // register indexes
   typedef enum logic [CSR_A_W-1:0] {
      CSR_LAYOUT = 3'd0,
      CSR_MONO   = 3'd1,
      CSR_PERIOD = 3'd2,
      CSR_SYNC   = 3'd3,
      CSR_PORCH  = 3'd4,
      CSR_SCAN   = 3'd5,
      CSR_SEP    = 3'd6,
      CSR_PIXELS = 3'd7
   } csr_addr_type;

   // configuration as seen by the datapath; pixels never holds zero
   typedef struct packed {
      logic [LAYOUT_W-1:0] layout;
      logic                mono;
      logic [PERIOD_W-1:0] period;
      logic [DUR_W-1:0]    sync;
      logic [DUR_W-1:0]    porch;
      logic [DUR_W-1:0]    scan;
      logic [DUR_W-1:0]    sep;
      logic [PIX_W-1:0]    pixels;
   } cfg_type;

   // decode stage result
   typedef struct packed {
      logic               present;
      logic [MLT_W-1:0]   mfac;
      logic [KF_W-1:0]    kfac;
      logic [OPR_W-1:0]   op0;
      logic [OPR_W-1:0]   op1;
      logic [OPR_W-1:0]   op2;
      logic [OPR_W-1:0]   op3;
   } dec_type;

   // multiply stage result
   typedef struct packed {
      logic               present;
      logic [LPROD_W-1:0] line_prod;
      logic [NUM_W-1:0]   num;
      logic [ADD_W-1:0]   add;
   } front_type;

   // data riding alongside the divider
   typedef struct packed {
      logic              present;
      logic [BASE_W-1:0] base;
   } side_type;

endpackage

// ----- rtl/sspt_csr.sv -----
// ----------------------------------------------------------------------------
// sspt_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module sspt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sspt_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [sspt_pkg::CSR_D_W-1:0]  csr_wdata,
   output sspt_pkg::cfg_type             cfg
);
   import sspt_pkg::*;

   cfg_type cfg_ff;

   assign cfg = cfg_ff;

   // register writes; a zero pixel count is stored as one
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout <= LAYOUT_SEQ;
         cfg_ff.mono   <= 1'b0;
         cfg_ff.period <= PERIOD_W'(446446000);
         cfg_ff.sync   <= DUR_W'(4862000);
         cfg_ff.porch  <= DUR_W'(572000);
         cfg_ff.scan   <= DUR_W'(146432000);
         cfg_ff.sep    <= DUR_W'(572000);
         cfg_ff.pixels <= PIX_W'(320);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LAYOUT: cfg_ff.layout <= csr_wdata[LAYOUT_W-1:0];
            CSR_MONO:   cfg_ff.mono   <= csr_wdata[0];
            CSR_PERIOD: cfg_ff.period <= csr_wdata[PERIOD_W-1:0];
            CSR_SYNC:   cfg_ff.sync   <= csr_wdata[DUR_W-1:0];
            CSR_PORCH:  cfg_ff.porch  <= csr_wdata[DUR_W-1:0];
            CSR_SCAN:   cfg_ff.scan   <= csr_wdata[DUR_W-1:0];
            CSR_SEP:    cfg_ff.sep    <= csr_wdata[DUR_W-1:0];
            CSR_PIXELS: begin
               cfg_ff.pixels <= (csr_wdata[PIX_W-1:0] == '0) ? PIX_W'(1)
                                                             : csr_wdata[PIX_W-1:0];
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/sspt_front.sv -----
// ----------------------------------------------------------------------------
// sspt_front
// Decode stage (layout rules, presence, operand selection) followed by the
// multiply stage (line product, divider numerator, addend sum).
// ----------------------------------------------------------------------------
module sspt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [sspt_pkg::Y_W-1:0]   line_index,
   input  logic [sspt_pkg::X_W-1:0]   column_index,
   input  logic [sspt_pkg::CH_W-1:0]  channel,
   input  sspt_pkg::cfg_type          cfg,
   output logic                       out_valid,
   output sspt_pkg::front_type        out_data
);
   import sspt_pkg::*;

   dec_type   dec_in;
   dec_type   dec_ff;
   logic      dec_valid_ff;
   front_type front_in;
   front_type front_ff;
   logic      front_valid_ff;

   logic [X_W:0]    odd2;
   logic [KF_W-1:0] k_full;
   logic [KF_W-1:0] k_half;
   logic [KF_W-1:0] k_r72;
   logic [OPR_W-1:0] s1, s2, h1, c1, c2, e1, e2;
   logic            in_range;

   // operand candidates
   assign odd2   = {column_index, 1'b1};
   assign k_full = {1'b0, odd2, 1'b0};
   assign k_half = {2'b00, odd2};
   assign k_r72  = {1'b0, cfg.pixels, 1'b0} + {2'b00, odd2};
   assign s1     = {1'b0, cfg.sync};
   assign s2     = {cfg.sync, 1'b0};
   assign h1     = {1'b0, cfg.porch};
   assign c1     = {1'b0, cfg.scan};
   assign c2     = {cfg.scan, 1'b0};
   assign e1     = {1'b0, cfg.sep};
   assign e2     = {cfg.sep, 1'b0};

   assign in_range = (channel != CHAN_3) && ({1'b0, line_index} < MAX_LINES) &&
                     ({1'b0, column_index} < MAX_PIXELS) &&
                     !(cfg.mono && (channel != CHAN_0));

   // decode: offset = k*C/(4n); time = m*P + op0..op3 + offset
   always_comb begin
      dec_in         = '0;
      dec_in.present = in_range;
      dec_in.mfac    = {1'b0, line_index};
      dec_in.kfac    = k_full;
      case (cfg.layout)
         LAYOUT_SEQ: begin
            dec_in.op0 = s1;
            dec_in.op1 = h1;
            if (channel == CHAN_1) begin
               dec_in.op2 = c1;
               dec_in.op3 = e1;
            end else if (channel == CHAN_2) begin
               dec_in.op2 = c2;
               dec_in.op3 = e2;
            end
         end
         LAYOUT_SCOTTIE: begin
            if (channel == CHAN_2) begin
               dec_in.op0 = s2;
               dec_in.op1 = e2;
               dec_in.op2 = e1;
               dec_in.op3 = c2;
            end else if (channel == CHAN_1) begin
               dec_in.op0 = s1;
               dec_in.op1 = e2;
               dec_in.op2 = c1;
            end else begin
               dec_in.op0 = s1;
               dec_in.op1 = e1;
            end
         end
         LAYOUT_PD: begin
            dec_in.mfac = {2'b00, line_index[Y_W-1:1]};
            dec_in.op0  = s1;
            dec_in.op1  = h1;
            if (channel == CHAN_0) begin
               if (line_index[0]) begin
                  dec_in.op2 = c2;
                  dec_in.op3 = c1;
               end
            end else if (line_index[0]) begin
               dec_in.present = 1'b0;
            end else if (channel == CHAN_1) begin
               dec_in.op2 = c1;
            end else begin
               dec_in.op2 = c2;
            end
         end
         LAYOUT_R72: begin
            dec_in.op0 = s1;
            dec_in.op1 = h1;
            if (channel == CHAN_1) begin
               dec_in.op2  = c1;
               dec_in.op3  = e1;
               dec_in.kfac = k_half;
            end else if (channel == CHAN_2) begin
               dec_in.op2  = c1;
               dec_in.op3  = e2;
               dec_in.kfac = k_r72;
            end
         end
         LAYOUT_R36: begin
            dec_in.op0 = s1;
            dec_in.op1 = h1;
            if (channel != CHAN_0) begin
               dec_in.present = dec_in.present && !line_index[0];
               dec_in.op2     = c1;
               dec_in.op3     = e1;
               dec_in.kfac    = k_half;
               if (channel == CHAN_2) begin
                  dec_in.mfac = {1'b0, line_index} + MLT_W'(1);
               end
            end
         end
         default: begin
            dec_in.present = 1'b0;
         end
      endcase
   end

   // multiply stage
   always_comb begin
      front_in.present   = dec_ff.present;
      front_in.line_prod = dec_ff.mfac * cfg.period;
      front_in.num       = dec_ff.kfac * cfg.scan;
      front_in.add       = ADD_W'(dec_ff.op0) + ADD_W'(dec_ff.op1) +
                           ADD_W'(dec_ff.op2) + ADD_W'(dec_ff.op3);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff   <= 1'b0;
         front_valid_ff <= 1'b0;
      end else if (en) begin
         dec_valid_ff   <= in_valid;
         front_valid_ff <= dec_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff   <= dec_in;
         front_ff <= front_in;
      end
   end

   assign out_valid = front_valid_ff;
   assign out_data  = front_ff;

endmodule

// ----- rtl/sspt_div.sv -----
// ----------------------------------------------------------------------------
// sspt_div
// Pipelined restoring divider, one quotient bit per stage, numerator / 4n.
// The first stage also forms the base time that rides along.
// ----------------------------------------------------------------------------
module sspt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  sspt_pkg::front_type           in_data,
   input  logic [sspt_pkg::DVS_W-1:0]    divisor,
   output logic                          out_valid,
   output logic [sspt_pkg::NUM_W-1:0]    out_quot,
   output sspt_pkg::side_type            out_side
);
   import sspt_pkg::*;

   logic               valid_ff [NUM_W];
   logic [DVS_W-1:0]   rem_ff   [NUM_W];
   logic [NUM_W-1:0]   num_ff   [NUM_W];
   logic [NUM_W-1:0]   quot_ff  [NUM_W];
   side_type           side_ff  [NUM_W];

   logic               valid_in [NUM_W];
   logic [DVS_W-1:0]   rem_in   [NUM_W];
   logic [NUM_W-1:0]   num_in   [NUM_W];
   logic [NUM_W-1:0]   quot_in  [NUM_W];
   side_type           side_in  [NUM_W];

   side_type           side_first;

   assign side_first.present = in_data.present;
   assign side_first.base    = BASE_W'(in_data.line_prod) + BASE_W'(in_data.add);

   // one trial subtraction per stage
   always_comb begin
      logic [DVS_W-1:0] rem_prev;
      logic [NUM_W-1:0] num_prev;
      logic [NUM_W-1:0] quot_prev;
      logic [DVS_W:0]   trial;
      logic             fits;
      for (int i = 0; i < NUM_W; i++) begin
         if (i == 0) begin
            valid_in[i] = in_valid;
            rem_prev    = '0;
            num_prev    = in_data.num;
            quot_prev   = '0;
            side_in[i]  = side_first;
         end else begin
            valid_in[i] = valid_ff[i-1];
            rem_prev    = rem_ff[i-1];
            num_prev    = num_ff[i-1];
            quot_prev   = quot_ff[i-1];
            side_in[i]  = side_ff[i-1];
         end
         trial      = {rem_prev, num_prev[NUM_W-1]};
         fits       = (trial >= {1'b0, divisor});
         rem_in[i]  = fits ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
         num_in[i]  = {num_prev[NUM_W-2:0], 1'b0};
         quot_in[i] = {quot_prev[NUM_W-2:0], fits};
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_W; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         for (int i = 0; i < NUM_W; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            num_ff[i]  <= num_in[i];
            quot_ff[i] <= quot_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ----- rtl/sspt_out.sv -----
// ----------------------------------------------------------------------------
// sspt_out
// Final add and saturation into an output register backed by a skid entry.
// The pipeline advances whenever the skid entry is free.
// ----------------------------------------------------------------------------
module sspt_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [sspt_pkg::NUM_W-1:0]    in_quot,
   input  sspt_pkg::side_type            in_side,
   output logic                          pipe_en,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sspt_pkg::TIME_W-1:0]   rsp_time,
   output logic                          rsp_present
);
   import sspt_pkg::*;

   logic [SUM_W-1:0]  total;
   logic [TIME_W-1:0] time_in;
   logic              item_in;

   logic              out_valid_ff;
   logic [TIME_W-1:0] out_time_ff;
   logic              out_present_ff;
   logic              skid_valid_ff;
   logic [TIME_W-1:0] skid_time_ff;
   logic              skid_present_ff;
   logic              load_out;

   // base + offset, clamped; absent channels read zero
   assign total   = SUM_W'(in_side.base) + SUM_W'(in_quot);
   assign time_in = !in_side.present ? '0 :
                    (total > TIME_MAX) ? TIME_MAX[TIME_W-1:0] : total[TIME_W-1:0];

   assign pipe_en  = !skid_valid_ff;
   assign item_in  = in_valid && pipe_en;
   assign load_out = !out_valid_ff || rsp_tready;

   // output and skid valids
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff  <= skid_valid_ff || item_in;
         skid_valid_ff <= 1'b0;
      end else if (item_in) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output and skid payloads
   always_ff @(posedge clock) begin
      if (load_out) begin
         if (skid_valid_ff) begin
            out_time_ff    <= skid_time_ff;
            out_present_ff <= skid_present_ff;
         end else begin
            out_time_ff    <= time_in;
            out_present_ff <= in_side.present;
         end
      end else if (item_in) begin
         skid_time_ff    <= time_in;
         skid_present_ff <= in_side.present;
      end
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_time    = out_time_ff;
   assign rsp_present = out_present_ff;

endmodule

// ----- rtl/sstv_pixel_sample_time.sv -----
// ----------------------------------------------------------------------------
// sstv_pixel_sample_time
// SSTV pixel sampling instant generator, one coordinate per clock when not back-pressured.
// ----------------------------------------------------------------------------
// For each (line, column, channel) the block returns the sampling instant in
// whole nanoseconds after image start and a present flag, under one of five
// timing layouts (sequential, Scottie, PD, Robot 72/24, Robot 36). A new
// coordinate is taken every cycle while the skid entry is free; each result
// passes through one decode stage, one multiply stage, 43 divider stages (one
// quotient bit each for the pixel offset, numerator over 4 x pixels_per_line)
// and one output stage with a skid entry. Output back-pressure halts the whole
// pipeline only once the skid entry is taken. Configuration must be written
// only while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sstv_pixel_sample_time (
   input  logic                         clock,
   input  logic                         reset,
   // coordinate in
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,   // line_index[8:0], column_index[18:9],
                                                     // channel[20:19], zero pad
   // result out
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [39:0]                  rsp_tdata,   // sample_time_ns[39:0]
   output logic                         rsp_tuser,   // present
   // configuration
   input  logic                         csr_we,
   input  logic [sspt_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [sspt_pkg::CSR_D_W-1:0] csr_wdata
);
   import sspt_pkg::*;

   cfg_type          cfg;
   logic             pipe_en;
   logic             front_valid;
   front_type        front_data;
   logic             div_valid;
   logic [NUM_W-1:0] div_quot;
   side_type         div_side;
   logic [DVS_W-1:0] divisor;

   assign req_tready = pipe_en;
   assign divisor    = {cfg.pixels, 2'b00};

   sspt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sspt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (pipe_en),
      .in_valid     (req_tvalid),
      .line_index   (req_tdata[8:0]),
      .column_index (req_tdata[18:9]),
      .channel      (req_tdata[20:19]),
      .cfg          (cfg),
      .out_valid    (front_valid),
      .out_data     (front_data)
   );

   sspt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .divisor   (divisor),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   sspt_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (div_valid),
      .in_quot     (div_quot),
      .in_side     (div_side),
      .pipe_en     (pipe_en),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_time    (rsp_tdata),
      .rsp_present (rsp_tuser)
   );

endmodule

// ----- rtl/sspt_checker.sv -----
// ----------------------------------------------------------------------------
// sspt_checker
// Port-level checks of the sample-time block, bound to the top level.
// ----------------------------------------------------------------------------
module sspt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an absent channel always reads time zero
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("absent channel with nonzero time");

   // input back-pressure only while a result is waiting
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

endmodule

bind sstv_pixel_sample_time sspt_checker u_sspt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- dv/sstv_pixel_sample_time_tb.sv -----
// ----------------------------------------------------------------------------
// sstv_pixel_sample_time_tb
// Self-checking bench for the SSTV pixel sample-time pipeline.
// ----------------------------------------------------------------------------
// Coordinates go in on the req stream and results come back on the rsp
// stream. Every accepted coordinate is predicted with exact 64-bit integer
// math from the current register settings and queued. Each returned result
// is compared field by field with the oldest queued prediction. A short
// directed table covers reset values, every layout, mono mode, absent
// channels, spare layouts, saturation and the minimum settings. Random
// phases then reprogram the registers between drained bursts. Both stream
// sides idle at random, and one long receiver hold-off backs up the pipe.
// ----------------------------------------------------------------------------
module sstv_pixel_sample_time_tb;
   import sspt_pkg::*;

   localparam logic [LAYOUT_W-1:0] LAYOUT_SPARE_LO = 3'd5;
   localparam logic [LAYOUT_W-1:0] LAYOUT_SPARE_HI = 3'd7;
   localparam logic [TIME_W-1:0]   TIME_SAT        = TIME_W'(TIME_MAX);
   localparam int PHASES       = 18;
   localparam int PHASE_ITEMS  = 90;
   localparam int HOLD_OFF     = 400;   // long receiver stall, in cycles
   localparam int DRAIN_CYCLES = 64;    // a bit more than the pipe depth

   typedef enum logic [1:0] {BASE_RESET, BASE_MAX, BASE_MIN} base_cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] stamp_ns;
      logic              present;
   } sample_type;

   typedef struct packed {
      base_cfg_type        base;
      logic [LAYOUT_W-1:0] layout;
      logic                mono;
      logic [Y_W-1:0]      y;
      logic [X_W-1:0]      x;
      logic [CH_W-1:0]     ch;
      logic                typed;   // want holds a hand-computed result
      sample_type          want;
   } coord_row_type;

   // directed coordinates; untyped rows go through the predictor
   coord_row_type directed_rows [25] = '{
      '{BASE_RESET, LAYOUT_SEQ, 1'b0, 9'd0, 10'd0, CHAN_0, 1'b1, '{40'd5662800, 1'b1}},
      '{BASE_RESET, LAYOUT_SEQ, 1'b0, 9'd511, 10'd1023, CHAN_2, 1'b1,
        '{40'd228901701600, 1'b1}},
      '{BASE_RESET, LAYOUT_SEQ, 1'b0, 9'd5, 10'd7, CHAN_3, 1'b1, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_SEQ, 1'b1, 9'd3, 10'd10, CHAN_1, 1'b1, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_SEQ, 1'b1, 9'd3, 10'd10, CHAN_0, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_SEQ, 1'b1, 9'd3, 10'd10, CHAN_2, 1'b1, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_SCOTTIE, 1'b0, 9'd2, 10'd100, CHAN_1, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_SCOTTIE, 1'b0, 9'd2, 10'd100, CHAN_2, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_PD, 1'b0, 9'd6, 10'd5, CHAN_0, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_PD, 1'b0, 9'd7, 10'd5, CHAN_0, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_PD, 1'b0, 9'd6, 10'd5, CHAN_1, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_PD, 1'b0, 9'd7, 10'd5, CHAN_1, 1'b1, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_PD, 1'b0, 9'd6, 10'd5, CHAN_2, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_R72, 1'b0, 9'd1, 10'd319, CHAN_0, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_R72, 1'b0, 9'd1, 10'd319, CHAN_1, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_R72, 1'b0, 9'd1, 10'd319, CHAN_2, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_R36, 1'b0, 9'd8, 10'd0, CHAN_1, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_R36, 1'b0, 9'd9, 10'd0, CHAN_1, 1'b1, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_R36, 1'b0, 9'd9, 10'd0, CHAN_2, 1'b1, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_R36, 1'b0, 9'd8, 10'd0, CHAN_2, 1'b0, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_SPARE_LO, 1'b0, 9'd0, 10'd0, CHAN_0, 1'b1, '{40'd0, 1'b0}},
      '{BASE_RESET, LAYOUT_SPARE_HI, 1'b0, 9'd1, 10'd1, CHAN_1, 1'b1, '{40'd0, 1'b0}},
      '{BASE_MAX, LAYOUT_SEQ, 1'b0, 9'd511, 10'd1023, CHAN_0, 1'b1, '{TIME_SAT, 1'b1}},
      '{BASE_MIN, LAYOUT_SEQ, 1'b0, 9'd0, 10'd0, CHAN_0, 1'b1, '{40'd0, 1'b1}},
      '{BASE_MIN, LAYOUT_R72, 1'b0, 9'd511, 10'd1023, CHAN_2, 1'b0, '{40'd0, 1'b0}}
   };

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [23:0]         req_tdata;    // line_index[8:0], column_index[18:9],
                                      // channel[20:19], zero pad
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [39:0]         rsp_tdata;    // sample_time_ns[39:0]
   logic                rsp_tuser;    // present
   logic                csr_we;
   csr_addr_type        csr_addr;
   logic [CSR_D_W-1:0]  csr_wdata;

   cfg_type             active_cfg;
   sample_type          expected_samples [$];
   int                  mismatch_count;
   int unsigned         sender_idle_pct;
   int unsigned         receiver_stall_pct;
   int                  hold_off_cycles;

   sstv_pixel_sample_time dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // sample instant and presence of one coordinate, exact integer math
   function automatic sample_type predict_sample(cfg_type c, logic [Y_W-1:0] y,
                                                 logic [X_W-1:0] x, logic [CH_W-1:0] ch);
      logic [63:0] n, odd2, off, hoff, lead, line_t, t;
      logic [63:0] period, sync, scan, sep, chn;
      logic        ok;
      sample_type  r;
      n      = (c.pixels == '0) ? 64'd1 : 64'(c.pixels);
      period = 64'(c.period);
      sync   = 64'(c.sync);
      scan   = 64'(c.scan);
      sep    = 64'(c.sep);
      chn    = 64'(ch);
      odd2   = 64'd2 * 64'(x) + 64'd1;
      off    = (odd2 * scan) / (64'd2 * n);
      hoff   = (odd2 * scan) / (64'd4 * n);
      lead   = sync + 64'(c.porch);
      line_t = 64'(y) * period;
      t      = '0;
      ok     = (ch != CHAN_3) && !(c.mono && ch != CHAN_0);
      if (ok) begin
         case (c.layout)
            LAYOUT_SEQ: begin
               t = line_t + lead + chn * (scan + sep) + off;
            end
            LAYOUT_SCOTTIE: begin
               t = line_t + off + sync + (chn + 64'd1) * sep + chn * scan
                   + ((ch == CHAN_2) ? sync : 64'd0);
            end
            LAYOUT_PD: begin
               // two image lines share one transmitted line
               t = 64'(y >> 1) * period + lead + off;
               if (ch == CHAN_0) begin
                  if (y[0]) t = t + 64'd3 * scan;
               end else if (!y[0]) begin
                  t = t + chn * scan;
               end else begin
                  ok = 1'b0;
               end
            end
            LAYOUT_R72: begin
               t = line_t + lead;
               if (ch == CHAN_0) t = t + off;
               else if (ch == CHAN_1) t = t + scan + sep + hoff;
               else t = t + scan + 64'd2 * sep
                        + (64'd2 * n * scan + odd2 * scan) / (64'd4 * n);
            end
            LAYOUT_R36: begin
               // chroma only on even lines, second chroma rides the next line
               if (ch == CHAN_0) t = line_t + lead + off;
               else if (y[0]) ok = 1'b0;
               else if (ch == CHAN_1) t = line_t + lead + scan + sep + hoff;
               else t = line_t + period + lead + scan + sep + hoff;
            end
            default: ok = 1'b0;
         endcase
      end
      if (!ok) t = '0;
      if (t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
      r.stamp_ns = t[TIME_W-1:0];
      r.present  = ok;
      return r;
   endfunction

   function automatic cfg_type base_settings(base_cfg_type b);
      cfg_type s;
      case (b)
         BASE_MAX: s = '{layout: LAYOUT_SEQ, mono: 1'b0, period: 31'h7FFF_FFFF,
                         sync: 30'h3FFF_FFFF, porch: 30'h3FFF_FFFF, scan: 30'h3FFF_FFFF,
                         sep: 30'h3FFF_FFFF, pixels: 11'h7FF};
         BASE_MIN: s = '{layout: LAYOUT_SEQ, mono: 1'b0, period: 31'd1, sync: 30'd0,
                         porch: 30'd0, scan: 30'd1, sep: 30'd0, pixels: 11'd0};
         default:  s = '{layout: LAYOUT_SEQ, mono: 1'b0, period: 31'd446446000,
                         sync: 30'd4862000, porch: 30'd572000, scan: 30'd146432000,
                         sep: 30'd572000, pixels: 11'd320};
      endcase
      return s;
   endfunction

   // a duration: ends of the range, anywhere in it, or a moderate value
   function automatic logic [30:0] pick_span(logic [30:0] lo, logic [30:0] hi);
      case ($urandom_range(7))
         0:       return lo;
         1:       return hi;
         2, 3:    return 31'($urandom_range(hi, lo));
         default: return 31'($urandom_range(hi >> 4, lo));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      if ($urandom_range(9) == 0)
         s.layout = LAYOUT_W'($urandom_range(LAYOUT_SPARE_HI, LAYOUT_SPARE_LO));
      else
         s.layout = LAYOUT_W'($urandom_range(LAYOUT_R36, LAYOUT_SEQ));
      s.mono   = ($urandom_range(4) == 0);
      s.period = pick_span(31'd1, 31'h7FFF_FFFF);
      s.sync   = DUR_W'(pick_span(31'd0, 31'h3FFF_FFFF));
      s.porch  = DUR_W'(pick_span(31'd0, 31'h3FFF_FFFF));
      s.scan   = DUR_W'(pick_span(31'd1, 31'h3FFF_FFFF));
      s.sep    = DUR_W'(pick_span(31'd0, 31'h3FFF_FFFF));
      case ($urandom_range(9))
         0:       s.pixels = 11'd0;
         1:       s.pixels = 11'h7FF;
         2:       s.pixels = 11'd1;
         3:       s.pixels = 11'd1024;
         default: s.pixels = PIX_W'($urandom_range(1024, 1));
      endcase
      return s;
   endfunction

   // write all registers, one per cycle; call only with the pipe empty
   task automatic program_settings(input cfg_type s);
      csr_addr_type a;
      for (int i = 0; i <= CSR_PIXELS; i++) begin
         a = csr_addr_type'(i);
         csr_we   <= 1'b1;
         csr_addr <= a;
         case (a)
            CSR_LAYOUT: csr_wdata <= CSR_D_W'(s.layout);
            CSR_MONO:   csr_wdata <= CSR_D_W'(s.mono);
            CSR_PERIOD: csr_wdata <= CSR_D_W'(s.period);
            CSR_SYNC:   csr_wdata <= CSR_D_W'(s.sync);
            CSR_PORCH:  csr_wdata <= CSR_D_W'(s.porch);
            CSR_SCAN:   csr_wdata <= CSR_D_W'(s.scan);
            CSR_SEP:    csr_wdata <= CSR_D_W'(s.sep);
            default:    csr_wdata <= CSR_D_W'(s.pixels);
         endcase
         @(negedge clock);
      end
      csr_we <= 1'b0;
      active_cfg = s;
   endtask

   // stop offering and wait for every outstanding result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
   endtask

   // offer one coordinate, with random idle cycles ahead of it
   task automatic send_coord(input logic [Y_W-1:0] y, input logic [X_W-1:0] x,
                             input logic [CH_W-1:0] ch, input sample_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, ch, x, y};
      do @(posedge clock); while (!req_tready);
      expected_samples = {expected_samples, want};
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // compare each returned result with the oldest prediction
   always @(posedge clock) begin : check_results
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $error("result with no coordinate outstanding: sample_time_ns %0d present %0d",
                   rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata !== want.stamp_ns) begin
               $error("sample_time_ns: expected %0d, got %0d", want.stamp_ns, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.present) begin
               $error("present: expected %0d, got %0d", want.present, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      coord_row_type     row;
      cfg_type           target;
      logic [Y_W-1:0]    y;
      logic [X_W-1:0]    x;
      logic [CH_W-1:0]   ch;
      int unsigned       x_span;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      csr_we             = 1'b0;
      csr_addr           = CSR_LAYOUT;
      csr_wdata          = '0;
      mismatch_count     = 0;
      hold_off_cycles    = 0;
      sender_idle_pct    = 12;
      receiver_stall_pct = 50;
      active_cfg         = base_settings(BASE_RESET);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; registers change only between drained rows
      for (int i = 0; i < $size(directed_rows); i++) begin
         row           = directed_rows[i];
         target        = base_settings(row.base);
         target.layout = row.layout;
         target.mono   = row.mono;
         if (target != active_cfg) begin
            settle();
            program_settings(target);
         end
         send_coord(row.y, row.x, row.ch,
                    row.typed ? row.want : predict_sample(active_cfg, row.y, row.x, row.ch));
      end

      // random phases, each with fresh register settings
      for (int p = 0; p < PHASES; p++) begin
         settle();
         program_settings(random_settings());
         if (p < PHASES / 3) begin
            sender_idle_pct    = 12;
            receiver_stall_pct = 50;
         end else if (p < 2 * PHASES / 3) begin
            sender_idle_pct    = 50;
            receiver_stall_pct = 12;
         end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         if (p == PHASES - 4) hold_off_cycles = HOLD_OFF;
         x_span = (active_cfg.pixels == '0) ? 1 :
                  (active_cfg.pixels > 11'd1024) ? 1024 : active_cfg.pixels;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(9) == 0) y = $urandom_range(1) ? 9'd511 : 9'd0;
            else y = Y_W'($urandom_range(511));
            // mostly columns on the scan, the rest anywhere in the field
            if ($urandom_range(3) != 0) x = X_W'($urandom_range(x_span - 1));
            else x = X_W'($urandom_range(1023));
            if ($urandom_range(19) == 0) ch = CHAN_3;
            else ch = CH_W'($urandom_range(CHAN_2, CHAN_0));
            send_coord(y, x, ch, predict_sample(active_cfg, y, x, ch));
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
